### rtl/decode_slot_stop_update_core_defines.svh
// Assertion macros shared by the decode slot stop update RTL.
`ifndef DECODE_SLOT_STOP_UPDATE_CORE_DEFINES_SVH
`define DECODE_SLOT_STOP_UPDATE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge outside reset.
`define DSSU_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DSSU_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DSSU_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons)
`define DSSU_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)

`endif

`endif

### rtl/dssu_pkg.sv
// Types and constants for the decode slot stop update block.
`default_nettype none

package dssu_pkg;

  localparam int unsigned LEN_W       = 20;
  localparam int unsigned TOK_W       = 32;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned ENDCNT_W    = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned NUM_END_TOKENS = 4;
  localparam int unsigned IN_W        = 168;
  localparam int unsigned OUT_W       = 152;

  localparam logic [LEN_W-1:0] LEN_MAX   = '1;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [TOK_W-1:0] TOKEN_NONE = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_END_TOKEN_0     = 3'd0,
    REG_END_TOKEN_1     = 3'd1,
    REG_END_TOKEN_2     = 3'd2,
    REG_END_TOKEN_3     = 3'd3,
    REG_END_TOKEN_COUNT = 3'd4,
    REG_STOP_THRESHOLD  = 3'd5
  } cfg_reg_t;

  // Input word, first field in the highest bits.
  typedef struct packed {
    logic                    pad;
    logic                    active;
    logic [LEN_W-1:0]        max_decode_len;
    logic                    block_step;
    logic signed [TOK_W-1:0] kwargs_token;
    logic signed [TOK_W-1:0] sampled_token;
    logic [LEN_W-1:0]        len_decoder;
    logic [LEN_W-1:0]        len_encoder;
    logic [LEN_W-1:0]        len_this_time;
    logic                    slot_stopped;
    logic [LEN_W-1:0]        step_index;
  } in_word_t;

  // Result word, first field in the highest bits.
  typedef struct packed {
    logic [4:0]              pad;
    logic                    keep_running;
    logic                    token_write;
    logic signed [TOK_W-1:0] kwargs_token_out;
    logic signed [TOK_W-1:0] sampled_token_out;
    logic [LEN_W-1:0]        len_decoder_out;
    logic [LEN_W-1:0]        len_encoder_out;
    logic [LEN_W-1:0]        len_this_time_out;
    logic                    slot_stopped_out;
    logic [LEN_W-1:0]        step_index_out;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/decode_slot_stop_update_core.sv
// Top level of the decode slot stop update block: per-slot stop and length bookkeeping.
// A word accepted at a rising edge sits in the input register and is worked into the
// result register when that is empty or being read, and offered on the master side.
// Throughput: one word per cycle with no gaps while the master side keeps tready high; the
// input register lets a new word in while the result register waits to be taken.
// Reset (synchronous, active high) empties both registers, clears the count, restores config.
`default_nettype none
`include "decode_slot_stop_update_core_defines.svh"

module decode_slot_stop_update_core
  import dssu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Slave side, one batch slot per word.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // step_index, slot_stopped, len_this_time, len_encoder, len_decoder, sampled_token,
  // kwargs_token, block_step, max_decode_len, active, one zero pad bit.
  input  wire logic [IN_W-1:0]       s_axis_tdata,
  input  wire logic                  s_axis_tlast,
  // Master side, one result per slot.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // step_index_out, slot_stopped_out, len_this_time_out, len_encoder_out, len_decoder_out,
  // sampled_token_out, kwargs_token_out, token_write, keep_running, five zero pad bits.
  output logic [OUT_W-1:0]           m_axis_tdata,
  output logic                       m_axis_tlast
);

  // Configuration registers. The end tokens are each read at their own place.
  logic [TOK_W-1:0]    end_tok [NUM_END_TOKENS];
  logic [ENDCNT_W-1:0] end_token_count;
  logic [CNT_W-1:0]    stop_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_END_TOKENS; i++) begin
        end_tok[i] <= '0;
      end
      end_token_count <= ENDCNT_W'(1);
      stop_threshold  <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_END_TOKEN_0:     end_tok[0]      <= cfg_data;
        REG_END_TOKEN_1:     end_tok[1]      <= cfg_data;
        REG_END_TOKEN_2:     end_tok[2]      <= cfg_data;
        REG_END_TOKEN_3:     end_tok[3]      <= cfg_data;
        REG_END_TOKEN_COUNT: end_token_count <= cfg_data[ENDCNT_W-1:0];
        REG_STOP_THRESHOLD:  stop_threshold  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register. It lets the slave side take a word while the result register
  // still holds one that the master side has not yet taken.
  in_word_t in_word;
  logic     in_last;
  logic     in_valid;
  logic     advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_word <= in_word_t'(s_axis_tdata);
      in_last <= s_axis_tlast;
    end
  end

  // Per-slot update. A slot that is not stopped moves one step on, saturating; it
  // stops once the step count reaches its limit.
  logic [LEN_W-1:0]        step_new;
  logic                    stop_step;
  logic signed [TOK_W-1:0] tok_new;
  logic signed [TOK_W-1:0] kw_new;
  logic [ENDCNT_W-1:0]     cmp_count;
  logic                    end_match;
  logic                    stop_new;
  logic                    counts;
  logic [LEN_W:0]          len_sum;
  logic [LEN_W-1:0]        dec_new;
  logic [CNT_W-1:0]        stopped_count;
  logic [CNT_W-1:0]        count_inc;
  logic [CNT_W-1:0]        stopped_count_next;
  out_word_t               res_next;

  always_comb begin
    if (!in_word.slot_stopped && in_word.step_index != LEN_MAX) begin
      step_new = in_word.step_index + LEN_W'(1);
    end else begin
      step_new = in_word.step_index;
    end
    stop_step = in_word.slot_stopped || (step_new >= in_word.max_decode_len);

    // A stopped slot that did work this step takes the first end token in both copies;
    // a stopped idle slot shows no token and keeps its previous copy.
    if (stop_step) begin
      if (in_word.len_this_time == '0) begin
        tok_new = TOKEN_NONE;
        kw_new  = in_word.kwargs_token;
      end else begin
        tok_new = end_tok[0];
        kw_new  = end_tok[0];
      end
    end else begin
      tok_new = in_word.sampled_token;
      kw_new  = in_word.sampled_token;
    end

    // Only the first end_token_count tokens take part; larger counts mean all of them.
    cmp_count = (end_token_count > ENDCNT_W'(NUM_END_TOKENS)) ?
                ENDCNT_W'(NUM_END_TOKENS) : end_token_count;
    end_match = 1'b0;
    for (int i = 0; i < NUM_END_TOKENS; i++) begin
      if (ENDCNT_W'(i) < cmp_count && tok_new == end_tok[i]) begin
        end_match = 1'b1;
      end
    end
    stop_new = stop_step || end_match;

    // New decoded length: folds in a pending prompt, else adds one token; saturates, zero on stop.
    if (in_word.len_encoder != '0) begin
      len_sum = {1'b0, in_word.len_encoder} + {1'b0, in_word.len_decoder};
    end else begin
      len_sum = {1'b0, in_word.len_decoder} + (LEN_W+1)'(1);
    end
    if (stop_new) begin
      dec_new = '0;
    end else if (len_sum[LEN_W]) begin
      dec_new = LEN_MAX;
    end else begin
      dec_new = len_sum[LEN_W-1:0];
    end

    res_next                = '0;
    res_next.step_index_out = step_new;
    if (in_word.active) begin
      res_next.slot_stopped_out  = stop_new;
      res_next.len_this_time_out = stop_new ? '0 : LEN_W'(1);
      res_next.len_encoder_out   = '0;
      res_next.len_decoder_out   = dec_new;
      res_next.sampled_token_out = tok_new;
      res_next.kwargs_token_out  = kw_new;
      res_next.token_write       = 1'b1;
      counts                     = stop_new && !in_word.block_step;
    end else begin
      // Slots outside the batch pass their length and token fields through and always count as stopped.
      res_next.slot_stopped_out  = stop_step;
      res_next.len_this_time_out = in_word.len_this_time;
      res_next.len_encoder_out   = in_word.len_encoder;
      res_next.len_decoder_out   = in_word.len_decoder;
      res_next.sampled_token_out = in_word.sampled_token;
      res_next.kwargs_token_out  = in_word.kwargs_token;
      res_next.token_write       = 1'b0;
      counts                     = 1'b1;
    end

    // Running count of stopped slots, saturating; compared and cleared on the last slot.
    count_inc = (counts && stopped_count != CNT_MAX) ?
                stopped_count + CNT_W'(1) : stopped_count;
    res_next.keep_running = in_last && (count_inc < stop_threshold);
    stopped_count_next    = in_last ? '0 : count_inc;
  end

  // Result register and the running count, both moved only when a word goes through.
  out_word_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      stopped_count <= '0;
    end else begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tvalid <= in_valid;
      end
      if (advance) begin
        stopped_count <= stopped_count_next;
      end
    end
    if (advance) begin
      res          <= res_next;
      m_axis_tlast <= in_last;
    end
  end

  assign m_axis_tdata = OUT_W'(res);

  // The stop verdict is only ever given with the last slot of a sweep.
  `DSSU_ASSERT_IMPLY(a_keep_only_last, clk, rst,
    m_axis_tvalid && res.keep_running, m_axis_tlast)
  // An active slot that keeps running reports one token this step, a stopped one none.
  `DSSU_ASSERT_IMPLY(a_active_len, clk, rst,
    m_axis_tvalid && res.token_write,
    res.len_this_time_out == (res.slot_stopped_out ? LEN_W'(0) : LEN_W'(1)))
  // A stopped active slot has its decoded length cleared.
  `DSSU_ASSERT_IMPLY(a_stopped_dec, clk, rst,
    m_axis_tvalid && res.token_write && res.slot_stopped_out, res.len_decoder_out == '0)
  // The count starts afresh after the last slot has gone through.
  `DSSU_ASSERT_NEXT(a_count_clear, clk, rst,
    advance && in_last, stopped_count == '0)

endmodule

`default_nettype wire
